FILE: sv/fbecho_pkg.sv
package fbecho_pkg;

    localparam int DELAY_DEPTH_DEFAULT = 65536;
    localparam int SAMPLE_W            = 16;
    localparam int CFG_W               = 16;
    localparam int CFG_INDEX_W         = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WET_MIX       = 2'd2;

    localparam logic [CFG_W-1:0] DELAY_SAMPLES_RESET = 16'd9600;
    localparam logic [CFG_W-1:0] FEEDBACK_GAIN_RESET = 16'd16384;
    localparam logic [CFG_W-1:0] WET_MIX_RESET       = 16'd16384;

    // unity in q1.15
    localparam logic [CFG_W-1:0] Q15_ONE = 16'd32768;

    typedef struct packed {
        logic [CFG_W-1:0] delay_samples;
        logic [CFG_W-1:0] feedback_gain;
        logic [CFG_W-1:0] wet_mix;
    } cfg_t;

    function automatic logic [CFG_W-1:0] clamp_gain(input logic [CFG_W-1:0] g);
        return (g > Q15_ONE) ? Q15_ONE : g;
    endfunction

    // clamp an 18-bit signed sum to the 16-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/fbecho_ifs.sv
interface fbecho_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fbecho_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: sv/fbecho_front.sv
module fbecho_front import fbecho_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEFAULT,
    parameter int ADDR_W      = $clog2(DELAY_DEPTH),
    parameter int QW          = 1 + 2 * ADDR_W + SAMPLE_W
) (
    input  logic            clk,
    input  logic            rst_n,
    fbecho_in_if.sink       samples,
    input  logic [CFG_W-1:0] delay_samples,
    output logic            push_valid,
    input  logic            push_ready,
    output logic [QW-1:0]   push_data
);

    logic [ADDR_W-1:0] wr_reg;
    logic [ADDR_W-1:0] wr_next;
    logic              wrapped_reg;
    logic              wrapped_next;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_valid;
    logic              push;

    assign samples.ready = push_ready;
    assign push_valid    = samples.valid;
    assign push          = samples.valid && push_ready;

    // ring wraps by masking; entries below the write index are filled until first wrap
    assign rd_addr  = wr_reg - ADDR_W'(delay_samples);
    assign rd_valid = wrapped_reg || (rd_addr < wr_reg);

    assign push_data = {rd_valid, rd_addr, wr_reg, samples.sample_in};

    always_comb
    begin
        wr_next      = wr_reg;
        wrapped_next = wrapped_reg;
        if (push)
        begin
            wr_next = wr_reg + 1'b1;
            if (wr_reg == '1)
            begin
                wrapped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            wr_reg      <= wr_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // fill flag is sticky until reset
    a_wrapped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(wrapped_reg))
        else $error("fill flag dropped");

    // the flag rises only on the transfer that writes the last entry
    a_wrap_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wrapped_reg) |-> ($past(wr_reg) == '1 && $past(push)))
        else $error("fill flag rose off the ring end");

    // each transfer moves the write slot by exactly one
    a_wr_step: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (wr_reg == $past(wr_reg) + 1'b1))
        else $error("write slot did not advance by one");

endmodule

FILE: sv/fbecho_queue.sv
module fbecho_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] entry_reg [2];
    logic         head_reg;
    logic         head_next;
    logic         tail_reg;
    logic         tail_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[head_reg];
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = ~tail_reg;
        end
        if (do_pop)
        begin
            head_next = ~head_reg;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (head_reg != tail_reg))
        else $error("queue pointers disagree with count");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |=> (count_reg != 2'd2))
        else $error("queue jumped from empty to full");

endmodule

FILE: sv/fbecho_back.sv
module fbecho_back import fbecho_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEFAULT,
    parameter int ADDR_W      = $clog2(DELAY_DEPTH),
    parameter int QW          = 1 + 2 * ADDR_W + SAMPLE_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          pop_valid,
    output logic          pop,
    input  logic [QW-1:0] pop_data,
    fbecho_out_if.source  results
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];

    logic                       q_rd_valid;
    logic [ADDR_W-1:0]          q_rd_addr;
    logic [ADDR_W-1:0]          q_wr_addr;
    logic signed [SAMPLE_W-1:0] q_sample;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [ADDR_W-1:0]          wr_addr_reg;
    logic                       rd_valid_reg;
    logic [SAMPLE_W-1:0]        rd_data_reg;
    logic signed [31:0]         prod1_reg;
    logic signed [47:0]         prod2_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic signed [SAMPLE_W-1:0] d_eff;
    logic signed [16:0]         gain_s;
    logic signed [16:0]         wet_s;
    logic signed [32:0]         p1;
    logic signed [48:0]         p2;
    logic signed [31:0]         echo_sum;
    logic signed [16:0]         echo;
    logic signed [47:0]         fed_sum;
    logic signed [16:0]         fed;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] stored;
    logic                       out_free;
    logic                       finish;

    assign {q_rd_valid, q_rd_addr, q_wr_addr, q_sample} = pop_data;

    assign pop      = (state_reg == ST_IDLE) && pop_valid;
    assign out_free = !out_valid_reg || results.ready;
    assign finish   = (state_reg == ST_DONE) && out_free;

    assign gain_s = $signed({1'b0, clamp_gain(cfg.feedback_gain)});
    assign wet_s  = $signed({1'b0, clamp_gain(cfg.wet_mix)});

    // an entry never written since reset reads as silence
    assign d_eff = rd_valid_reg ? $signed(rd_data_reg) : '0;
    assign p1    = d_eff * gain_s;
    assign p2    = prod1_reg * wet_s;

    // arithmetic shifts round toward minus infinity: bias negative products first so they truncate toward zero
    assign echo_sum = prod1_reg + (prod1_reg[31] ? 32'sd32767 : 32'sd0);
    assign echo     = echo_sum[31:15];
    assign fed_sum  = prod2_reg + (prod2_reg[47] ? 48'sd1073741823 : 48'sd0);
    assign fed      = fed_sum[46:30];

    assign y      = sat16({{2{sample_reg[15]}}, sample_reg} + {echo[16], echo});
    assign stored = sat16({{2{sample_reg[15]}}, sample_reg} + {fed[16], fed});

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg   <= q_sample;
            wr_addr_reg  <= q_wr_addr;
            rd_valid_reg <= q_rd_valid;
        end
        if (state_reg == ST_MUL1)
        begin
            prod1_reg <= p1[31:0];
        end
        if (state_reg == ST_MUL2)
        begin
            prod2_reg <= p2[47:0];
            y_reg     <= y;
        end
        if (finish)
        begin
            out_data_reg <= y_reg;
        end
    end

    // delay memory: one read port, one write port, registered read
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= mem[q_rd_addr];
        end
        if (finish)
        begin
            mem[wr_addr_reg] <= stored;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_data_reg;

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside the final step");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !results.ready) |=> (state_reg == ST_DONE))
        else $error("item retired while the result register was full");

    a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_MUL1))
        else $error("pop did not start an item");

endmodule

FILE: sv/feedback_echo_delay_core.sv
// feedback echo on a stream of signed 16-bit audio samples
//
// samples: valid/ready channel carrying sample_in, one transfer per sample
// results: valid/ready channel carrying sample_out, one transfer per sample,
//          in input order
// cfg_we/cfg_index/cfg_data: register write port (delay_samples, feedback_gain,
//          wet_mix), write only while no sample is in flight
//
// path: an accepted sample goes through the queue, the memory read, two multiplies
//          and the output register before it shows on results
// pacing: set by the back end, which runs memory read, two multiplies and the
//          memory write per sample before it reads for the next one
// reset: config registers take their defaults; the delay memory reads as
//          silence until each entry is first written, tracked by a fill
//          flag, so no clearing pass is needed and samples are accepted at once
// stall: a held result sits in the output register; the back end waits in
//          its final step, and the front keeps taking samples into a
//          two-entry queue until it fills, then drops ready
module feedback_echo_delay_core import fbecho_pkg::*; #(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    fbecho_in_if.sink              samples,
    fbecho_out_if.source           results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int QW     = 1 + 2 * ADDR_W + SAMPLE_W;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop;
    logic [QW-1:0] pop_data;

    // register writes; an index past the list is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY_SAMPLES: cfg_next.delay_samples = cfg_data;
                CFG_FEEDBACK_GAIN: cfg_next.feedback_gain = cfg_data;
                CFG_WET_MIX:       cfg_next.wet_mix       = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay_samples <= DELAY_SAMPLES_RESET;
            cfg_reg.feedback_gain <= FEEDBACK_GAIN_RESET;
            cfg_reg.wet_mix       <= WET_MIX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: takes samples, assigns write slot and read tap, flags unfilled taps
    fbecho_front #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .ADDR_W      (ADDR_W),
        .QW          (QW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples),
        .delay_samples (cfg_reg.delay_samples),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    // short queue so the front keeps taking samples while the back is busy
    fbecho_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    // back: delay memory read, gain multiplies, saturation, write back, result
    fbecho_back #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .ADDR_W      (ADDR_W),
        .QW          (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .results   (results)
    );

endmodule
